// ===== sv/wto_pkg.sv =====
// Shared types, widths and codes for the wavetable oscillator.
// Depends on nothing; all files but the RAM use it, the design by scoped names.
package wto_pkg;

	// Table geometry and fixed-point formats.
	localparam int TABLE_DEPTH   = 4096;
	localparam int IDX_W         = $clog2(TABLE_DEPTH);
	localparam int FRAC_W        = 20;
	localparam int SAMPLE_BITS   = 16;
	localparam int PHASE_W       = 32;
	localparam int FREQ_W        = 27;
	localparam int FREQ_FRAC     = 8;
	localparam int LEN_W         = 13;
	localparam int PPH_W         = 32;
	localparam int START_W       = 32;
	localparam int LF_W          = LEN_W + FRAC_W;
	localparam int PROD_W        = FREQ_W + PPH_W;
	localparam int PMAG_W        = PROD_W - FREQ_FRAC;
	localparam int SUM_W         = LF_W + 1;

	// Configuration port.
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 32;
	localparam logic [LEN_W-1:0] TABLE_LENGTH_RST = LEN_W'(4096);
	localparam logic [PPH_W-1:0] PHASE_PER_HZ_RST = PPH_W'(89478);
	localparam logic [START_W-1:0] START_PHASE_RST = '0;

	// Result queue.
	localparam int QUEUE_DEPTH   = 3;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		FUNC_TICK    = 2'd0,
		FUNC_WRITE   = 2'd1,
		FUNC_RESTART = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TABLE_LENGTH = 2'd0,
		CFG_PHASE_PER_HZ = 2'd1,
		CFG_START_PHASE  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0]   table_length;
		logic [PPH_W-1:0]   phase_per_hz;
		logic [START_W-1:0] start_phase;
	} cfg_t;

	// One accepted command beat as seen by the phase unit.
	typedef struct packed {
		logic              accept;
		logic [1:0]        func;
		logic [FREQ_W-1:0] frequency;
	} cmd_t;

	// Table read request issued by the phase unit.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} rd_req_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic [IDX_W-1:0]       table_index;
	} result_t;

endpackage

// ===== sv/wto_in_if.sv =====
// Command channel of the wavetable oscillator: valid/ready plus the command payload.
// Depends on wto_pkg for the field widths.
interface wto_in_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        func;
	logic signed [wto_pkg::FREQ_W-1:0] frequency;
	logic [wto_pkg::IDX_W-1:0]         table_address;
	logic signed [wto_pkg::SAMPLE_BITS-1:0] table_value;

	modport source (output valid, output func, output frequency, output table_address,
		output table_value, input ready);
	modport sink (input valid, input func, input frequency, input table_address,
		input table_value, output ready);
endinterface

// ===== sv/wto_out_if.sv =====
// Result channel of the wavetable oscillator: valid/ready plus sample and table index.
// Depends on wto_pkg for the field widths.
interface wto_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [wto_pkg::SAMPLE_BITS-1:0] sample;
	logic [wto_pkg::IDX_W-1:0]              table_index;

	modport source (output valid, output sample, output table_index, input ready);
	modport sink (input valid, input sample, input table_index, output ready);
endinterface

// ===== sv/wto_table_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; holds the wave table of the oscillator.
module wto_table_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data registered and held between reads.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/wto_phase.sv =====
// Phase accumulator and increment unit: keeps phase, cached frequency and increment,
// issues the table read for each tick. Depends on wto_pkg.
module wto_phase (
	input  logic             clk,
	input  logic             arst_n,
	input  wto_pkg::cfg_t    cfg,
	input  wto_pkg::cmd_t    cmd,
	output wto_pkg::rd_req_t rd,
	output logic             busy
);

	logic [wto_pkg::PHASE_W-1:0] phase_q;
	logic [wto_pkg::FREQ_W-1:0]  cached_q;
	logic                        step_neg_q;
	logic [wto_pkg::LF_W-1:0]    step_mag_q;
	logic                        busy_q;
	logic [wto_pkg::PROD_W-1:0]  prod_s1;
	logic                        neg_s1;

	logic [wto_pkg::LEN_W-1:0]   len_eff;
	logic [wto_pkg::LF_W-1:0]    lf;
	logic [wto_pkg::PHASE_W-1:0] lf_last;
	logic [wto_pkg::PHASE_W-1:0] phase_c;
	logic [wto_pkg::PHASE_W-1:0] start_c;
	logic                        is_tick;
	logic                        freq_same;
	logic                        tick_go;
	logic                        tick_new;
	logic                        restart;
	logic                        upd;
	logic [wto_pkg::FREQ_W-1:0]  freq_mag;
	logic [wto_pkg::PMAG_W-1:0]  mag_src;
	logic                        neg_src;
	logic [wto_pkg::LF_W-1:0]    mag_use;
	logic [wto_pkg::SUM_W-1:0]   sum_up;
	logic [wto_pkg::SUM_W-1:0]   sum_wrap;
	logic [wto_pkg::SUM_W-1:0]   dif_dn;
	logic [wto_pkg::SUM_W-1:0]   dif_wrap;
	logic [wto_pkg::PHASE_W-1:0] next_phase;

	// Effective table length: zero acts as one, anything above the depth as the depth.
	always_comb begin
		if (cfg.table_length == '0) begin
			len_eff = wto_pkg::LEN_W'(1);
		end else if (cfg.table_length > wto_pkg::LEN_W'(wto_pkg::TABLE_DEPTH)) begin
			len_eff = wto_pkg::LEN_W'(wto_pkg::TABLE_DEPTH);
		end else begin
			len_eff = cfg.table_length;
		end
	end

	assign lf      = {len_eff, {wto_pkg::FRAC_W{1'b0}}};
	assign lf_last = wto_pkg::PHASE_W'(lf - wto_pkg::LF_W'(1));

	// Phase and start phase saturated to just below the table length.
	assign phase_c = ({1'b0, phase_q} >= lf) ? lf_last : phase_q;
	assign start_c = ({1'b0, cfg.start_phase} >= lf) ? lf_last : cfg.start_phase;

	// Command decode.
	assign is_tick   = cmd.accept && (cmd.func == wto_pkg::FUNC_TICK);
	assign freq_same = (cmd.frequency == cached_q);
	assign tick_go   = is_tick && freq_same;
	assign tick_new  = is_tick && !freq_same;
	assign restart   = cmd.accept && (cmd.func == wto_pkg::FUNC_RESTART);
	assign upd       = tick_go || busy_q;

	// Magnitude of the signed frequency for the multiplier.
	assign freq_mag = cmd.frequency[wto_pkg::FREQ_W-1] ? (~cmd.frequency + 1'b1)
		: cmd.frequency;

	// Increment source: a fresh product while a frequency change is pending (busy),
	// otherwise the stored increment; either way saturated to one table length.
	always_comb begin
		if (busy_q) begin
			mag_src = prod_s1[wto_pkg::PROD_W-1 -: wto_pkg::PMAG_W];
			neg_src = neg_s1;
		end else begin
			mag_src = wto_pkg::PMAG_W'(step_mag_q);
			neg_src = step_neg_q;
		end
		mag_use = (mag_src > wto_pkg::PMAG_W'(lf)) ? lf : mag_src[wto_pkg::LF_W-1:0];
	end

	// Advance the phase and wrap once into the table length.
	always_comb begin
		sum_up   = wto_pkg::SUM_W'(phase_c) + wto_pkg::SUM_W'(mag_use);
		sum_wrap = sum_up - wto_pkg::SUM_W'(lf);
		dif_dn   = wto_pkg::SUM_W'(phase_c) - wto_pkg::SUM_W'(mag_use);
		dif_wrap = dif_dn + wto_pkg::SUM_W'(lf);
		if (neg_src) begin
			next_phase = dif_dn[wto_pkg::SUM_W-1] ? dif_wrap[wto_pkg::PHASE_W-1:0]
				: dif_dn[wto_pkg::PHASE_W-1:0];
		end else begin
			next_phase = sum_wrap[wto_pkg::SUM_W-1] ? sum_up[wto_pkg::PHASE_W-1:0]
				: sum_wrap[wto_pkg::PHASE_W-1:0];
		end
	end

	// Multiplier stage: one product per frequency change.
	always_ff @(posedge clk) begin
		if (tick_new) begin
			prod_s1 <= wto_pkg::PROD_W'(freq_mag) * wto_pkg::PROD_W'(cfg.phase_per_hz);
			neg_s1  <= cmd.frequency[wto_pkg::FREQ_W-1];
		end
	end

	// Oscillator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			cached_q   <= '0;
			step_neg_q <= 1'b0;
			step_mag_q <= '0;
			busy_q     <= 1'b0;
		end else begin
			if (restart) begin
				phase_q    <= start_c;
				cached_q   <= '0;
				step_neg_q <= 1'b0;
				step_mag_q <= '0;
			end
			if (tick_new) begin
				cached_q <= cmd.frequency;
				busy_q   <= 1'b1;
			end
			if (busy_q) begin
				busy_q     <= 1'b0;
				step_neg_q <= neg_s1;
				step_mag_q <= mag_use;
			end
			if (upd) begin
				phase_q <= next_phase;
			end
		end
	end

	assign rd.en  = upd;
	assign rd.idx = phase_c[wto_pkg::PHASE_W-1 -: wto_pkg::IDX_W];
	assign busy   = busy_q;

endmodule

// ===== sv/wto_out_queue.sv =====
// Small result queue that decouples the table read pipeline from the result channel.
// Depends on wto_pkg and wto_out_if.
module wto_out_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  wto_pkg::result_t           push_data,
	output logic [wto_pkg::QCNT_W-1:0] level,
	wto_out_if.source                  result
);

	wto_pkg::result_t              mem_q [wto_pkg::QUEUE_DEPTH];
	logic [wto_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [wto_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [wto_pkg::QCNT_W-1:0]    cnt_q;
	logic                          pop;

	assign pop = result.valid && result.ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == wto_pkg::QPTR_W'(wto_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == wto_pkg::QPTR_W'(wto_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign result.valid       = (cnt_q != '0);
	assign result.sample      = mem_q[rd_ptr_q].sample;
	assign result.table_index = mem_q[rd_ptr_q].table_index;
	assign level              = cnt_q;

endmodule

// ===== sv/wavetable_oscillator.sv =====
// Wavetable oscillator top level. A tick's result passes the registered table read and the
// result queue before it is offered; a tick with a frequency other than the cached one
// first passes the multiplier register. Throughput: one item per cycle while the result
// queue has room; a tick with a new frequency holds the command channel until its product
// is used (the multiply-to-phase-register loop). Reset loads the registers with defaults,
// clears phase, cached frequency and increment, but not the table RAM (invalid until written).
module wavetable_oscillator (
	input  logic                             clk,
	input  logic                             arst_n,
	wto_in_if.sink                           command,
	wto_out_if.source                        result,
	input  logic                             cfg_we,
	input  logic [wto_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wto_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	wto_pkg::cfg_t                 cfg_q;
	wto_pkg::cmd_t                 cmd;
	wto_pkg::rd_req_t              rd;
	wto_pkg::result_t              res_s1;
	logic                          busy;
	logic                          accept;
	logic                          tbl_we;
	logic [wto_pkg::SAMPLE_BITS-1:0] rdata;
	logic                          v_s1;
	logic [wto_pkg::IDX_W-1:0]     idx_s1;
	logic [wto_pkg::QCNT_W-1:0]    level;
	logic [wto_pkg::QCNT_W:0]      in_flight;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.table_length <= wto_pkg::TABLE_LENGTH_RST;
			cfg_q.phase_per_hz <= wto_pkg::PHASE_PER_HZ_RST;
			cfg_q.start_phase  <= wto_pkg::START_PHASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wto_pkg::CFG_TABLE_LENGTH:
					cfg_q.table_length <= cfg_wdata[wto_pkg::LEN_W-1:0];
				wto_pkg::CFG_PHASE_PER_HZ:
					cfg_q.phase_per_hz <= cfg_wdata[wto_pkg::PPH_W-1:0];
				wto_pkg::CFG_START_PHASE:
					cfg_q.start_phase <= cfg_wdata[wto_pkg::START_W-1:0];
				default: ;
			endcase
		end
	end

	// Accept a beat while no product is pending and the queue has room for it.
	assign in_flight     = wto_pkg::QCNT_W'(level) + (wto_pkg::QCNT_W + 1)'(v_s1);
	assign command.ready = !busy && (in_flight < (wto_pkg::QCNT_W + 1)'(wto_pkg::QUEUE_DEPTH));
	assign accept        = command.valid && command.ready;

	assign cmd.accept    = accept;
	assign cmd.func      = command.func;
	assign cmd.frequency = command.frequency;

	assign tbl_we = accept && (command.func == wto_pkg::FUNC_WRITE);

	wto_phase u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.rd     (rd),
		.busy   (busy)
	);

	wto_table_ram #(
		.DEPTH (wto_pkg::TABLE_DEPTH),
		.WIDTH (wto_pkg::SAMPLE_BITS)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (command.table_address),
		.wdata (command.table_value),
		.re    (rd.en),
		.raddr (rd.idx),
		.rdata (rdata)
	);

	// Read stage: tracks which cycle the RAM output holds a fresh sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= rd.en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			idx_s1 <= rd.idx;
		end
	end

	assign res_s1.sample      = rdata;
	assign res_s1.table_index = idx_s1;

	wto_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s1),
		.push_data (res_s1),
		.level     (level),
		.result    (result)
	);

`ifndef SYNTHESIS
	// The queue, the read stage and a pending tick never exceed the queue depth.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_flight + (wto_pkg::QCNT_W + 1)'(busy))
			<= (wto_pkg::QCNT_W + 1)'(wto_pkg::QUEUE_DEPTH))
		else $error("result queue overflow");

	// A pending product blocks the command channel.
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !command.ready)
		else $error("command accepted while a product is pending");

	// A pending product only follows an accepted tick.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(accept && (command.func == wto_pkg::FUNC_TICK)))
		else $error("product pending without a tick");

	// A fresh read sample always reaches the result channel next cycle.
	a_read_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> result.valid)
		else $error("read sample lost");

	// A table write never falls in the same cycle as a read for a pending product.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(tbl_we && busy && rd.en))
		else $error("table write during pending read");
`endif

endmodule

// ===== bench/wavetable_oscillator_tb.sv =====
// Self-checking testbench for the wavetable oscillator: directed and random command beats,
// each result checked against a predicted phase, increment and table copy.
// Depends on wto_pkg, the wto_in_if and wto_out_if interfaces and wavetable_oscillator.
module wavetable_oscillator_tb;
	import wto_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [FREQ_W-1:0] FREQ_MAX = {1'b0, {(FREQ_W-1){1'b1}}};
	localparam logic [FREQ_W-1:0] FREQ_MIN = {1'b1, {(FREQ_W-1){1'b0}}};
	localparam logic [FREQ_W-1:0] FREQ_1KHZ = FREQ_W'(1000 << FREQ_FRAC);
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int RANDOM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int FILL_ENTRIES = 30;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	wto_in_if  command_bus();
	wto_out_if result_bus();

	wavetable_oscillator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.command  (command_bus),
		.result   (result_bus),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Copies of the configuration registers.
	logic [LEN_W-1:0]   length_reg;
	logic [PPH_W-1:0]   rate_reg;
	logic [START_W-1:0] start_reg;

	// Predicted oscillator state and table contents.
	logic [PHASE_W-1:0]     phase_acc;
	logic [FREQ_W-1:0]      last_freq;
	longint                 phase_step;
	logic [SAMPLE_BITS-1:0] table_copy [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] written_map;
	result_t                pending_samples [$];

	int idle_pct = 16;
	int stall_pct = 16;
	int hold_off_len = 0;
	int errors = 0;
	int cycle_count = 0;
	int beats_sent = 0;
	int ticks_sent = 0;
	int writes_sent = 0;
	int restarts_sent = 0;
	int noise_sent = 0;
	int results_checked = 0;

	// Free-running clock, period 2.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Phase span in fixed point, with the out-of-range lengths folded in.
	function automatic longint table_span();
		longint n;
		n = longint'(length_reg);
		if (n == 0) n = 1;
		if (n > TABLE_DEPTH) n = TABLE_DEPTH;
		return n << FRAC_W;
	endfunction

	// Random signed frequency with a random magnitude width, so small and large rates both occur.
	function automatic logic [FREQ_W-1:0] rand_freq();
		int unsigned         width;
		logic [FREQ_W-1:0]   mask;
		logic [FREQ_W-1:0]   pick;
		width = $urandom_range(FREQ_W, 1);
		mask = (FREQ_W'(1) << width) - 1'b1;
		pick = FREQ_W'($urandom) & mask;
		if ($urandom_range(1) == 1) pick = -pick;
		return pick;
	endfunction

	// Apply one accepted command beat to the predicted state; ticks queue their expected result.
	task automatic advance_oscillator(input logic [1:0] fn, input logic [FREQ_W-1:0] freq,
			input logic [IDX_W-1:0] addr, input logic [SAMPLE_BITS-1:0] value);
		longint            span;
		longint            ph;
		longint            nxt;
		longint            prod;
		longint            step;
		logic [FREQ_W-1:0] mag;
		result_t           want;
		span = table_span();
		case (fn)
			FUNC_WRITE: begin
				table_copy[addr] = value;
				written_map[addr] = 1'b1;
			end
			FUNC_RESTART: begin
				ph = longint'(start_reg);
				if (ph >= span) ph = span - 1;
				phase_acc = PHASE_W'(ph);
				last_freq = '0;
				phase_step = 0;
			end
			FUNC_TICK: begin
				// Read at the phase as stored, clipped below a lowered length.
				ph = longint'(phase_acc);
				if (ph >= span) ph = span - 1;
				want.table_index = IDX_W'(ph >> FRAC_W);
				want.sample = table_copy[ph >> FRAC_W];
				// A new frequency recomputes the increment, magnitude truncated, then saturated.
				if (freq != last_freq) begin
					mag = freq[FREQ_W-1] ? -freq : freq;
					prod = longint'((64'(mag) * 64'(rate_reg)) >> FREQ_FRAC);
					if (prod > span) prod = span;
					phase_step = freq[FREQ_W-1] ? -prod : prod;
					last_freq = freq;
				end
				// The kept increment is saturated again against the current length.
				step = phase_step;
				if (step > span) step = span;
				if (step < -span) step = -span;
				nxt = ph + step;
				if (nxt >= span) nxt -= span;
				else if (nxt < 0) nxt += span;
				phase_acc = PHASE_W'(nxt);
				pending_samples.push_back(want);
			end
			default: begin
			end
		endcase
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("mismatch at cycle %0d: %s, expected %h, got %h", cycle_count, what, want, got);
		errors++;
	endtask

	// Send one command beat after a random idle gap and wait for the handshake.
	task automatic send_beat(input logic [1:0] fn, input logic [FREQ_W-1:0] freq,
			input logic [IDX_W-1:0] addr, input logic [SAMPLE_BITS-1:0] value);
		while ($urandom_range(99) < idle_pct) begin
			command_bus.valid <= 1'b0;
			@(posedge clk);
		end
		command_bus.valid <= 1'b1;
		command_bus.func <= fn;
		command_bus.frequency <= freq;
		command_bus.table_address <= addr;
		command_bus.table_value <= value;
		@(posedge clk);
		while (!command_bus.ready) @(posedge clk);
		beats_sent++;
		advance_oscillator(fn, freq, addr, value);
	endtask

	task automatic write_entry(input logic [IDX_W-1:0] addr, input logic [SAMPLE_BITS-1:0] value);
		send_beat(FUNC_WRITE, FREQ_W'($urandom), addr, value);
		writes_sent++;
	endtask

	// Ticks read only loaded entries: an entry that was never loaded gets a write first.
	task automatic tick(input logic [FREQ_W-1:0] freq);
		longint ph;
		ph = longint'(phase_acc);
		if (ph >= table_span()) ph = table_span() - 1;
		if (!written_map[IDX_W'(ph >> FRAC_W)])
			write_entry(IDX_W'(ph >> FRAC_W), SAMPLE_BITS'($urandom));
		send_beat(FUNC_TICK, freq, IDX_W'($urandom), SAMPLE_BITS'($urandom));
		ticks_sent++;
	endtask

	task automatic restart();
		send_beat(FUNC_RESTART, FREQ_W'($urandom), IDX_W'($urandom), SAMPLE_BITS'($urandom));
		restarts_sent++;
	endtask

	task automatic send_noise();
		send_beat(FUNC_UNUSED, FREQ_W'($urandom), IDX_W'($urandom), SAMPLE_BITS'($urandom));
		noise_sent++;
	endtask

	// Stop sending and wait until every expected result has arrived.
	task automatic pause_for_results();
		command_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_samples.size() != 0) @(posedge clk);
	endtask

	// Full quiet point: results drained and beats without results given time to retire.
	task automatic settle_block();
		pause_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; only called while the block is settled.
	task automatic write_register(input cfg_idx_t which, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (which)
			CFG_TABLE_LENGTH: length_reg = value[LEN_W-1:0];
			CFG_PHASE_PER_HZ: rate_reg = value[PPH_W-1:0];
			CFG_START_PHASE:  start_reg = value[START_W-1:0];
			default: begin
			end
		endcase
	endtask

	// Load the extreme samples at both ends and a few random entries; any other entry
	// is loaded by the tick that is about to read it.
	task automatic test_table_fill();
		write_entry('0, 16'h8000);
		write_entry(IDX_W'(TABLE_DEPTH - 1), 16'h7FFF);
		for (int a = 0; a < FILL_ENTRIES; a++) begin
			write_entry(IDX_W'($urandom), SAMPLE_BITS'($urandom));
		end
		settle_block();
	endtask

	// Zero, saturating and ordinary rates in both directions at the reset settings.
	task automatic test_tick_extremes();
		longint ph;
		restart();
		tick('0);
		tick('0);
		tick(FREQ_MAX);
		tick(FREQ_MAX);
		tick(FREQ_MIN);
		tick(FREQ_MIN);
		tick(FREQ_1KHZ);
		tick(FREQ_1KHZ);
		tick(-FREQ_1KHZ);
		send_noise();
		// Overwrite the entry about to be read and read it straight back.
		ph = longint'(phase_acc);
		if (ph >= table_span()) ph = table_span() - 1;
		write_entry(IDX_W'(ph >> FRAC_W), 16'h0000);
		tick(FREQ_1KHZ);
		settle_block();
	endtask

	// A rate change alone keeps the old increment until the frequency changes or a restart.
	task automatic test_stale_increment();
		write_register(CFG_PHASE_PER_HZ, '1);
		tick(last_freq);
		tick(FREQ_W'(1));
		restart();
		tick('0);
		tick(FREQ_W'(1));
		settle_block();
	endtask

	// Lowering the length clips the stored phase and the kept increment.
	task automatic test_lowered_length();
		write_register(CFG_PHASE_PER_HZ, CFG_DATA_W'(PHASE_PER_HZ_RST));
		write_register(CFG_START_PHASE, CFG_DATA_W'((3000 << FRAC_W) + 12345));
		restart();
		tick(FREQ_MAX);
		settle_block();
		write_register(CFG_TABLE_LENGTH, CFG_DATA_W'(100));
		tick(FREQ_MAX);
		tick('0);
		settle_block();
	endtask

	// Length zero acts as one, lengths past the table act as the table; start phase clipped.
	task automatic test_length_limits();
		write_register(CFG_TABLE_LENGTH, '0);
		write_register(CFG_START_PHASE, '1);
		restart();
		tick(rand_freq());
		tick(rand_freq());
		settle_block();
		write_register(CFG_TABLE_LENGTH, CFG_DATA_W'({LEN_W{1'b1}}));
		restart();
		tick(FREQ_MIN);
		tick(rand_freq());
		settle_block();
	endtask

	// Random phases: each sets all registers, then mostly runs of ticks on a held tone.
	task automatic test_random_phases();
		logic [LEN_W-1:0]   len;
		logic [PPH_W-1:0]   rate;
		logic [START_W-1:0] start;
		logic [FREQ_W-1:0]  tone;
		int                 first_beat;
		int                 roll;
		tone = rand_freq();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle_block();
			// One phase runs with no idling on either side.
			idle_pct = (p == 3) ? 0 : 16;
			stall_pct = (p == 3) ? 0 : 16;
			case (p)
				0: begin
					len = TABLE_LENGTH_RST;
					rate = PHASE_PER_HZ_RST;
					start = START_PHASE_RST;
				end
				1: begin
					len = LEN_W'(1);
					rate = '1;
					start = START_W'($urandom);
				end
				2: begin
					len = LEN_W'(TABLE_DEPTH);
					rate = '0;
					start = '1;
				end
				5: begin
					len = {LEN_W{1'b1}};
					rate = PPH_W'($urandom);
					start = START_W'($urandom);
				end
				default: begin
					if ($urandom_range(1) == 1) len = LEN_W'($urandom_range(64, 2));
					else len = LEN_W'($urandom_range(TABLE_DEPTH, 1));
					if ($urandom_range(1) == 1) rate = PPH_W'($urandom_range(400000));
					else rate = PPH_W'($urandom);
					start = START_W'($urandom);
				end
			endcase
			write_register(CFG_TABLE_LENGTH, CFG_DATA_W'(len));
			write_register(CFG_PHASE_PER_HZ, CFG_DATA_W'(rate));
			write_register(CFG_START_PHASE, CFG_DATA_W'(start));
			restart();
			first_beat = beats_sent;
			while (beats_sent - first_beat < ITEMS_PER_PHASE) begin
				roll = $urandom_range(99);
				if (roll < 7) begin
					restart();
				end else if (roll < 17) begin
					write_entry(IDX_W'($urandom), SAMPLE_BITS'($urandom));
				end else if (roll < 20) begin
					send_noise();
				end else if (roll < 22) begin
					pause_for_results();
				end else begin
					if ($urandom_range(99) < 12) tone = rand_freq();
					tick(tone);
				end
			end
		end
		idle_pct = 16;
		stall_pct = 16;
		settle_block();
	endtask

	// Hold the result side off for a long stretch while ticks keep coming.
	task automatic test_result_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		hold_off_len = HOLD_OFF_CYCLES;
		for (int i = 0; i < 40; i++) begin
			if (i % 2 == 0) tick(rand_freq());
			else tick(last_freq);
		end
		idle_pct = 16;
		stall_pct = 16;
		settle_block();
	endtask

	// Result side: random stalls, or a counted hold-off when one is requested.
	initial begin : result_stalls
		int held;
		held = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_len != 0) begin
				held = hold_off_len;
				hold_off_len = 0;
			end
			if (held != 0) begin
				result_bus.ready <= 1'b0;
				held--;
			end else begin
				result_bus.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Compare each accepted result beat with the oldest expectation.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_samples.size() == 0) begin
				flag_mismatch("result with nothing expected", '0,
					{4'h0, result_bus.table_index, result_bus.sample});
			end else begin
				want = pending_samples.pop_front();
				if (result_bus.sample !== want.sample)
					flag_mismatch("sample", 32'(want.sample), 32'(result_bus.sample));
				if (result_bus.table_index !== want.table_index)
					flag_mismatch("table index", 32'(want.table_index),
						32'(result_bus.table_index));
				results_checked++;
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_samples.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Reset, then the tests in turn, then the verdict.
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		command_bus.valid <= 1'b0;
		command_bus.func <= FUNC_TICK;
		command_bus.frequency <= '0;
		command_bus.table_address <= '0;
		command_bus.table_value <= '0;
		length_reg = TABLE_LENGTH_RST;
		rate_reg = PHASE_PER_HZ_RST;
		start_reg = START_PHASE_RST;
		phase_acc = '0;
		last_freq = '0;
		phase_step = 0;
		written_map = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_fill();
		test_tick_extremes();
		test_stale_increment();
		test_lowered_length();
		test_length_limits();
		test_random_phases();
		test_result_backpressure();
		settle_block();
		$display("%0d beats sent, %0d results checked from %0d ticks, %0d table writes,",
			beats_sent, results_checked, ticks_sent, writes_sent);
		$display("%0d restarts and %0d ignored beats; covered length and rate extremes,",
			restarts_sent, noise_sent);
		$display("stale and clipped increments and long stalls on both sides.");
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
